FILE: hdl/pdt_pkg.sv
// ----------------------------------------------------------------------------
// pdt_pkg - path data tokenizer shared definitions
// Token kinds, scan modes, character classes and the number scanner step.
// ----------------------------------------------------------------------------
package pdt_pkg;

    // First byte offset at which a non-NUL byte is refused as too long
    localparam logic [15:0] MAX_OFFSET = 16'hFFFF;

    // Result queue geometry
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    // Character codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_LO_E  = 8'h65;
    localparam logic [7:0] CH_UP_E  = 8'h45;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_Z  = 8'h7A;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;

    typedef enum logic [2:0] {
        KIND_CMD   = 3'd0,
        KIND_NUM   = 3'd1,
        KIND_COMMA = 3'd2,
        KIND_END   = 3'd3,
        KIND_ERR   = 3'd4
    } t_kind;

    typedef enum logic [7:0] {
        MODE_IDLE    = 8'b0000_0001,
        MODE_SIGN    = 8'b0000_0010,
        MODE_INT     = 8'b0000_0100,
        MODE_DOT     = 8'b0000_1000,
        MODE_FRAC    = 8'b0001_0000,
        MODE_EXP     = 8'b0010_0000,
        MODE_EXPSIGN = 8'b0100_0000,
        MODE_EXPDIG  = 8'b1000_0000
    } t_mode;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] start_pos;
        logic [15:0] token_len;
        logic [7:0]  letter;
        logic        last;
    } t_result;

    // Outcome of one byte inside an open number
    typedef struct packed {
        t_mode mode;
        logic  term;
        logic  err;
    } t_step;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= CH_LO_A) && (c <= CH_LO_Z)) || ((c >= CH_UP_A) && (c <= CH_UP_Z));
    endfunction

    function automatic logic is_sign(input logic [7:0] c);
        return (c == CH_MINUS) || (c == CH_PLUS);
    endfunction

    function automatic logic is_exp(input logic [7:0] c);
        return (c == CH_LO_E) || (c == CH_UP_E);
    endfunction

    function automatic logic is_term(input logic [7:0] c);
        return is_ws(c) || (c == CH_COMMA) || (c == CH_NUL);
    endfunction

    // Advance an open number by one byte
    function automatic t_step number_next(input t_mode mode, input logic [7:0] c);
        t_step s;
        s = '{mode: mode, term: 1'b0, err: 1'b0};
        unique case (mode)
            MODE_SIGN: begin
                if (is_digit(c)) s.mode = MODE_INT;
                else             s.err  = 1'b1;
            end
            MODE_DOT: begin
                if (is_digit(c)) s.mode = MODE_FRAC;
                else             s.err  = 1'b1;
            end
            MODE_EXPSIGN: begin
                if (is_digit(c)) s.mode = MODE_EXPDIG;
                else             s.err  = 1'b1;
            end
            MODE_EXP: begin
                if (is_digit(c))     s.mode = MODE_EXPDIG;
                else if (is_sign(c)) s.mode = MODE_EXPSIGN;
                else                 s.err  = 1'b1;
            end
            MODE_INT: begin
                if (is_digit(c))      s.mode = MODE_INT;
                else if (c == CH_DOT) s.mode = MODE_DOT;
                else if (is_exp(c))   s.mode = MODE_EXP;
                else if (is_term(c))  s.term = 1'b1;
                else                  s.err  = 1'b1;
            end
            MODE_FRAC: begin
                if (is_digit(c))     s.mode = MODE_FRAC;
                else if (is_exp(c))  s.mode = MODE_EXP;
                else if (is_term(c)) s.term = 1'b1;
                else                 s.err  = 1'b1;
            end
            MODE_EXPDIG: begin
                if (is_digit(c))     s.mode = MODE_EXPDIG;
                else if (is_term(c)) s.term = 1'b1;
                else                 s.err  = 1'b1;
            end
            default: begin
                s.err = 1'b1;
            end
        endcase
        return s;
    endfunction

endpackage

FILE: hdl/path_data_tokenizer.sv
// ----------------------------------------------------------------------------
// path_data_tokenizer - streaming lexer for path data strings
// Takes one byte per transfer and emits command, number, comma, end and
// error tokens through a small result queue.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+-------------------------
//  in      | input     | i_in_valid / o_in_ready    | i_ch
//  out     | output    | o_out_valid / i_out_ready  | o_kind, o_start_pos,
//          |           |                            | o_token_len, o_letter,
//          |           |                            | o_last
//
//  A byte is scanned in the cycle it is taken; its results are in the
//  four-entry result queue by the next cycle. One byte per cycle is taken
//  while the queue holds at most two results, and one-result bytes keep that
//  rate unless the output stalls; a byte that gives two results (a number
//  closed by a comma or NUL) needs two output transfers, which the output
//  port sets. Synchronous reset empties the queue and returns the scanner to
//  the idle mode at offset zero. A stall on the output only holds the queue;
//  the scanner keeps taking bytes until fewer than two entries are free.
//
module path_data_tokenizer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_ch,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_kind,
    output logic [15:0] o_start_pos,
    output logic [15:0] o_token_len,
    output logic [7:0]  o_letter,
    output logic        o_last
);

    // Scanner state
    pdt_pkg::t_mode r_mode, n_mode;
    logic [15:0]    r_pos, n_pos;
    logic [15:0]    r_nstart, n_nstart;
    logic           r_halt, n_halt;

    // Result queue
    pdt_pkg::t_result                 r_fifo [pdt_pkg::FIFO_DEPTH];
    logic [pdt_pkg::PTR_W-1:0]        r_wr_ptr, r_rd_ptr;
    logic [pdt_pkg::CNT_W-1:0]        r_count;

    logic             in_acc, out_acc;
    logic             push0, push1;
    pdt_pkg::t_result res0, res1;
    pdt_pkg::t_step   step;
    logic             in_number;
    logic [15:0]      err_start;
    logic [16:0]      err_len;
    logic [pdt_pkg::CNT_W-1:0] push_cnt;

    // Accept while at least two queue entries are free
    assign o_in_ready = (r_count <= pdt_pkg::CNT_W'(pdt_pkg::FIFO_DEPTH - 2));
    assign in_acc     = i_in_valid && o_in_ready;
    assign out_acc    = o_out_valid && i_out_ready;
    assign in_number  = (r_mode != pdt_pkg::MODE_IDLE);
    assign step       = pdt_pkg::number_next(r_mode, i_ch);
    assign err_start  = in_number ? r_nstart : r_pos;
    assign err_len    = {1'b0, r_pos} - {1'b0, err_start} + 17'd1;

    // Scan one byte: next state and up to two results
    always_comb begin
        n_mode   = r_mode;
        n_pos    = r_pos;
        n_nstart = r_nstart;
        n_halt   = r_halt;
        push0    = 1'b0;
        push1    = 1'b0;
        res0     = '{kind: pdt_pkg::KIND_ERR, start_pos: r_pos, token_len: 16'd0,
                     letter: 8'd0, last: 1'b1};
        res1     = '{kind: pdt_pkg::KIND_END, start_pos: r_pos, token_len: 16'd0,
                     letter: 8'd0, last: 1'b1};
        if (in_acc) begin
            priority if (r_halt) begin
                // drop bytes until the string ends
                if (i_ch == pdt_pkg::CH_NUL) begin
                    n_halt = 1'b0;
                end
            end else if (i_ch != pdt_pkg::CH_NUL && r_pos >= pdt_pkg::MAX_OFFSET) begin
                // string too long
                push0           = 1'b1;
                res0.start_pos  = err_start;
                res0.token_len  = err_len[15:0];
                n_halt          = 1'b1;
                n_mode          = pdt_pkg::MODE_IDLE;
            end else if (!in_number) begin
                priority if (i_ch == pdt_pkg::CH_NUL) begin
                    push0       = 1'b1;
                    res0.kind   = pdt_pkg::KIND_END;
                end else if (pdt_pkg::is_ws(i_ch)) begin
                    push0 = 1'b0;
                end else if (pdt_pkg::is_alpha(i_ch)) begin
                    push0          = 1'b1;
                    res0.kind      = pdt_pkg::KIND_CMD;
                    res0.token_len = 16'd1;
                    res0.letter    = i_ch;
                end else if (i_ch == pdt_pkg::CH_COMMA) begin
                    push0          = 1'b1;
                    res0.kind      = pdt_pkg::KIND_COMMA;
                    res0.token_len = 16'd1;
                end else if (pdt_pkg::is_digit(i_ch) || pdt_pkg::is_sign(i_ch)) begin
                    n_nstart = r_pos;
                    n_mode   = pdt_pkg::is_digit(i_ch) ? pdt_pkg::MODE_INT
                                                       : pdt_pkg::MODE_SIGN;
                end else begin
                    // stray byte
                    push0          = 1'b1;
                    res0.token_len = 16'd1;
                    n_halt         = 1'b1;
                end
            end else begin
                priority if (step.term) begin
                    push0          = 1'b1;
                    res0.kind      = pdt_pkg::KIND_NUM;
                    res0.start_pos = r_nstart;
                    res0.token_len = r_pos - r_nstart;
                    n_mode         = pdt_pkg::MODE_IDLE;
                    if (i_ch == pdt_pkg::CH_COMMA) begin
                        push1          = 1'b1;
                        res1.kind      = pdt_pkg::KIND_COMMA;
                        res1.token_len = 16'd1;
                    end else if (i_ch == pdt_pkg::CH_NUL) begin
                        push1 = 1'b1;
                    end
                    res0.last = !push1;
                end else if (step.err) begin
                    push0          = 1'b1;
                    res0.start_pos = r_nstart;
                    res0.token_len = err_len[15:0];
                    n_mode         = pdt_pkg::MODE_IDLE;
                    n_halt         = (i_ch != pdt_pkg::CH_NUL);
                end else begin
                    n_mode = step.mode;
                end
            end
            // NUL rearms at offset zero; other bytes advance with saturation
            if (i_ch == pdt_pkg::CH_NUL) begin
                n_mode   = pdt_pkg::MODE_IDLE;
                n_pos    = 16'd0;
                n_nstart = 16'd0;
            end else if (r_pos < pdt_pkg::MAX_OFFSET) begin
                n_pos = r_pos + 16'd1;
            end
        end
    end

    assign push_cnt = pdt_pkg::CNT_W'(push0) + pdt_pkg::CNT_W'(push1);

    // Scanner and queue control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= pdt_pkg::MODE_IDLE;
            r_pos    <= 16'd0;
            r_nstart <= 16'd0;
            r_halt   <= 1'b0;
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_mode   <= n_mode;
            r_pos    <= n_pos;
            r_nstart <= n_nstart;
            r_halt   <= n_halt;
            r_wr_ptr <= r_wr_ptr + pdt_pkg::PTR_W'(push_cnt);
            if (out_acc) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count  <= r_count + push_cnt - pdt_pkg::CNT_W'(out_acc);
        end
    end

    // Write results into the queue
    always_ff @(posedge i_clk) begin
        if (push0) begin
            r_fifo[r_wr_ptr] <= res0;
        end
        if (push1) begin
            r_fifo[r_wr_ptr + 1'b1] <= res1;
        end
    end

    // Present the queue head
    assign o_out_valid = (r_count != '0);
    assign o_kind      = r_fifo[r_rd_ptr].kind;
    assign o_start_pos = r_fifo[r_rd_ptr].start_pos;
    assign o_token_len = r_fifo[r_rd_ptr].token_len;
    assign o_letter    = r_fifo[r_rd_ptr].letter;
    assign o_last      = r_fifo[r_rd_ptr].last;

    // Checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= pdt_pkg::CNT_W'(pdt_pkg::FIFO_DEPTH))
        else $error("result queue overflow");

    a_nul_rearm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_ch == pdt_pkg::CH_NUL |=> r_pos == 16'd0 && r_mode == pdt_pkg::MODE_IDLE)
        else $error("NUL did not rearm scanner");

    a_halt_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halt |-> r_mode == pdt_pkg::MODE_IDLE)
        else $error("number open while halted");

    a_halt_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && r_halt |=> r_count <= $past(r_count))
        else $error("result produced while halted");

endmodule

FILE: dv/path_token_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// path_token_checker - scoreboard for the path data tokenizer
// Watches both channels, predicts the tokens of every transferred byte and
// compares each output transfer, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module path_token_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [7:0]  i_ch,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [2:0]  i_kind,
    input  logic [15:0] i_start_pos,
    input  logic [15:0] i_token_len,
    input  logic [7:0]  i_letter,
    input  logic        i_last,
    output int          o_fail_count,
    output int          o_token_count,
    output logic        o_drained
);

    localparam int unsigned POS_LIMIT = pdt_pkg::MAX_OFFSET;

    typedef enum logic [2:0] {
        CC_NUL,
        CC_SPACE,
        CC_DIGIT,
        CC_ALPHA,
        CC_SIGN,
        CC_DOT,
        CC_COMMA,
        CC_OTHER
    } t_char_class;

    // Predicted scanner state
    pdt_pkg::t_mode scan_state;
    int unsigned    byte_pos;
    int unsigned    number_origin;
    bit             string_halted;

    pdt_pkg::t_result expected_tokens[$];
    int               fail_total  = 0;
    int               token_total = 0;

    assign o_fail_count  = fail_total;
    assign o_token_count = token_total;

    function automatic t_char_class classify(input logic [7:0] c);
        logic [7:0] folded;
        folded = c | 8'h20;
        case (c)
            pdt_pkg::CH_NUL:   return CC_NUL;
            pdt_pkg::CH_SPACE, pdt_pkg::CH_TAB,
            pdt_pkg::CH_CR, pdt_pkg::CH_LF: return CC_SPACE;
            pdt_pkg::CH_COMMA: return CC_COMMA;
            pdt_pkg::CH_DOT:   return CC_DOT;
            pdt_pkg::CH_MINUS, pdt_pkg::CH_PLUS: return CC_SIGN;
            default: begin
                if (c >= pdt_pkg::CH_ZERO && c <= pdt_pkg::CH_NINE) return CC_DIGIT;
                if (folded >= pdt_pkg::CH_LO_A && folded <= pdt_pkg::CH_LO_Z) return CC_ALPHA;
                return CC_OTHER;
            end
        endcase
    endfunction

    function automatic pdt_pkg::t_result make_token(input pdt_pkg::t_kind k,
                                                    input int unsigned first,
                                                    input int unsigned len,
                                                    input logic [7:0] c);
        pdt_pkg::t_result r;
        r.kind      = k;
        r.start_pos = 16'(first);
        r.token_len = 16'(len);
        r.letter    = c;
        r.last      = 1'b0;
        return r;
    endfunction

    // Return to the start of a fresh string
    function automatic void rearm();
        scan_state    = pdt_pkg::MODE_IDLE;
        byte_pos      = 0;
        number_origin = 0;
    endfunction

    // Work out the tokens that one transferred byte gives
    task automatic scan_byte(input logic [7:0] c);
        t_char_class      cls;
        bit               exp_mark;
        bit               closes;
        bit               breaks;
        pdt_pkg::t_mode   nx;
        int unsigned      first;
        pdt_pkg::t_result made[2];
        int               made_n;
        cls      = classify(c);
        exp_mark = (c == pdt_pkg::CH_LO_E) || (c == pdt_pkg::CH_UP_E);
        closes   = 1'b0;
        breaks   = 1'b0;
        nx       = scan_state;
        made_n   = 0;

        // Drop everything up to the NUL after an error
        if (string_halted) begin
            if (cls == CC_NUL) begin
                string_halted = 1'b0;
                rearm();
            end
            return;
        end

        if (cls != CC_NUL && byte_pos >= POS_LIMIT) begin
            // String too long: error from the open number or this byte
            first = (scan_state != pdt_pkg::MODE_IDLE) ? number_origin : byte_pos;
            made[0] = make_token(pdt_pkg::KIND_ERR, first, byte_pos - first + 1, 8'h00);
            made_n = 1;
            string_halted = 1'b1;
            scan_state = pdt_pkg::MODE_IDLE;
        end else if (scan_state == pdt_pkg::MODE_IDLE) begin
            case (cls)
                CC_NUL: begin
                    made[0] = make_token(pdt_pkg::KIND_END, byte_pos, 0, 8'h00);
                    made_n = 1;
                    rearm();
                end
                CC_SPACE: begin
                end
                CC_ALPHA: begin
                    made[0] = make_token(pdt_pkg::KIND_CMD, byte_pos, 1, c);
                    made_n = 1;
                end
                CC_COMMA: begin
                    made[0] = make_token(pdt_pkg::KIND_COMMA, byte_pos, 1, 8'h00);
                    made_n = 1;
                end
                CC_DIGIT, CC_SIGN: begin
                    number_origin = byte_pos;
                    scan_state = (cls == CC_DIGIT) ? pdt_pkg::MODE_INT : pdt_pkg::MODE_SIGN;
                end
                default: begin
                    made[0] = make_token(pdt_pkg::KIND_ERR, byte_pos, 1, 8'h00);
                    made_n = 1;
                    string_halted = 1'b1;
                end
            endcase
        end else begin
            // Advance the open number
            case (scan_state)
                pdt_pkg::MODE_SIGN: begin
                    if (cls == CC_DIGIT) nx = pdt_pkg::MODE_INT;
                    else                 breaks = 1'b1;
                end
                pdt_pkg::MODE_DOT: begin
                    if (cls == CC_DIGIT) nx = pdt_pkg::MODE_FRAC;
                    else                 breaks = 1'b1;
                end
                pdt_pkg::MODE_EXPSIGN: begin
                    if (cls == CC_DIGIT) nx = pdt_pkg::MODE_EXPDIG;
                    else                 breaks = 1'b1;
                end
                pdt_pkg::MODE_EXP: begin
                    if (cls == CC_DIGIT)     nx = pdt_pkg::MODE_EXPDIG;
                    else if (cls == CC_SIGN) nx = pdt_pkg::MODE_EXPSIGN;
                    else                     breaks = 1'b1;
                end
                pdt_pkg::MODE_INT: begin
                    if (cls == CC_DIGIT)    nx = pdt_pkg::MODE_INT;
                    else if (cls == CC_DOT) nx = pdt_pkg::MODE_DOT;
                    else if (exp_mark)      nx = pdt_pkg::MODE_EXP;
                    else if (cls inside {CC_NUL, CC_SPACE, CC_COMMA}) closes = 1'b1;
                    else                    breaks = 1'b1;
                end
                pdt_pkg::MODE_FRAC: begin
                    if (cls == CC_DIGIT) nx = pdt_pkg::MODE_FRAC;
                    else if (exp_mark)   nx = pdt_pkg::MODE_EXP;
                    else if (cls inside {CC_NUL, CC_SPACE, CC_COMMA}) closes = 1'b1;
                    else                 breaks = 1'b1;
                end
                pdt_pkg::MODE_EXPDIG: begin
                    if (cls == CC_DIGIT) nx = pdt_pkg::MODE_EXPDIG;
                    else if (cls inside {CC_NUL, CC_SPACE, CC_COMMA}) closes = 1'b1;
                    else                 breaks = 1'b1;
                end
                default: begin
                    breaks = 1'b1;
                end
            endcase

            if (closes) begin
                made[0] = make_token(pdt_pkg::KIND_NUM, number_origin,
                                     byte_pos - number_origin, 8'h00);
                made_n = 1;
                scan_state = pdt_pkg::MODE_IDLE;
                if (cls == CC_COMMA) begin
                    made[1] = make_token(pdt_pkg::KIND_COMMA, byte_pos, 1, 8'h00);
                    made_n = 2;
                end else if (cls == CC_NUL) begin
                    made[1] = make_token(pdt_pkg::KIND_END, byte_pos, 0, 8'h00);
                    made_n = 2;
                    rearm();
                end
            end else if (breaks) begin
                made[0] = make_token(pdt_pkg::KIND_ERR, number_origin,
                                     byte_pos - number_origin + 1, 8'h00);
                made_n = 1;
                scan_state = pdt_pkg::MODE_IDLE;
                if (cls == CC_NUL) rearm();
                else               string_halted = 1'b1;
            end else begin
                scan_state = nx;
            end
        end

        // Advance the offset, saturating at the limit
        if (cls != CC_NUL && byte_pos < POS_LIMIT) byte_pos++;

        if (made_n > 0) made[made_n - 1].last = 1'b1;
        for (int i = 0; i < made_n; i++) expected_tokens.push_back(made[i]);
    endtask

    function automatic void compare_field(input string name, input logic [15:0] want,
                                          input logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_total++;
        end
    endfunction

    // Predict on input transfers, compare on output transfers
    always @(posedge i_clk) begin
        pdt_pkg::t_result want;
        if (!i_rst_n) begin
            string_halted = 1'b0;
            rearm();
            expected_tokens.delete();
            o_drained <= 1'b1;
        end else begin
            if (i_in_valid && i_in_ready) scan_byte(i_ch);
            if (i_out_valid && i_out_ready) begin
                if (expected_tokens.size() == 0) begin
                    $error("token transfer with no token predicted: kind %0d at %0d",
                           i_kind, i_start_pos);
                    fail_total++;
                end else begin
                    want = expected_tokens.pop_front();
                    compare_field("kind", 16'(want.kind), 16'(i_kind));
                    compare_field("start_pos", want.start_pos, i_start_pos);
                    compare_field("token_len", want.token_len, i_token_len);
                    compare_field("letter", 16'(want.letter), 16'(i_letter));
                    compare_field("last", 16'(want.last), 16'(i_last));
                    token_total++;
                end
            end
            o_drained <= (expected_tokens.size() == 0);
        end
    end

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench - path data tokenizer top level test
// Feeds directed corner strings and random well-formed and broken strings
// under random idling on both sides.
// ----------------------------------------------------------------------------
module testbench;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_BYTES   = 1550;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_TOGGLE
    } t_rx_pattern;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic [7:0]  ch        = 8'h00;
    logic        out_ready = 1'b0;
    logic        in_ready;
    logic        out_valid;
    logic [2:0]  kind;
    logic [15:0] start_pos;
    logic [15:0] token_len;
    logic [7:0]  letter;
    logic        last;
    logic        drained;
    int          fail_count;
    int          token_count;

    int          burst_left   = 0;
    int          bytes_sent   = 0;
    int          strings_sent = 0;
    int          idle_cycles  = 0;
    t_rx_pattern rx_pattern   = RX_OPEN;
    int          rx_left      = 0;
    logic [7:0]  text[$];

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    path_data_tokenizer dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_ch        (ch),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_kind      (kind),
        .o_start_pos (start_pos),
        .o_token_len (token_len),
        .o_letter    (letter),
        .o_last      (last)
    );

    path_token_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_ch          (ch),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_kind        (kind),
        .i_start_pos   (start_pos),
        .i_token_len   (token_len),
        .i_letter      (letter),
        .i_last        (last),
        .o_fail_count  (fail_count),
        .o_token_count (token_count),
        .o_drained     (drained)
    );

    // Receiver: switch between stall patterns in segments of random length
    always @(posedge clk) begin
        if (rx_left == 0) begin
            rx_pattern = t_rx_pattern'($urandom_range(0, 3));
            rx_left = $urandom_range(10, 120);
        end else begin
            rx_left--;
        end
        case (rx_pattern)
            RX_OPEN:   out_ready <= 1'b1;
            RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
            RX_SPARSE: out_ready <= ($urandom_range(0, 4) == 0);
            default:   out_ready <= ~out_ready;
        endcase
    end

    // Watchdog: end the run after a long stretch with no transfer
    initial begin
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
            else idle_cycles++;
        end
        $display("testbench: errors");
        $finish;
    end

    // Hold one byte until its transfer, idling between bursts
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 48);
        end
        in_valid <= 1'b1;
        ch <= b;
        do @(posedge clk); while (!(in_valid && in_ready));
        burst_left--;
        bytes_sent++;
    endtask

    task automatic send_buffer();
        foreach (text[i]) send_byte(text[i]);
        text.delete();
        strings_sent++;
    endtask

    task automatic send_literal(input string s);
        for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
        text.push_back(pdt_pkg::CH_NUL);
        send_buffer();
    endtask

    // Stop sending until every predicted token has come out
    task automatic wait_drained();
        in_valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (!drained) @(posedge clk);
    endtask

    function automatic logic [7:0] pick_space();
        case ($urandom_range(0, 3))
            0:       return pdt_pkg::CH_SPACE;
            1:       return pdt_pkg::CH_TAB;
            2:       return pdt_pkg::CH_CR;
            default: return pdt_pkg::CH_LF;
        endcase
    endfunction

    function automatic logic [7:0] pick_digit();
        return pdt_pkg::CH_ZERO + 8'($urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] pick_letter();
        if ($urandom_range(0, 1)) return 8'($urandom_range(pdt_pkg::CH_LO_A, pdt_pkg::CH_LO_Z));
        return 8'($urandom_range(pdt_pkg::CH_UP_A, pdt_pkg::CH_UP_Z));
    endfunction

    function automatic void add_digits(input int lo, input int hi);
        repeat ($urandom_range(lo, hi)) text.push_back(pick_digit());
    endfunction

    // Well-formed number: sign, digits, fraction and exponent at random
    function automatic void add_number();
        case ($urandom_range(0, 2))
            0: text.push_back(pdt_pkg::CH_MINUS);
            1: text.push_back(pdt_pkg::CH_PLUS);
            default: ;
        endcase
        add_digits(1, 4);
        if ($urandom_range(0, 1)) begin
            text.push_back(pdt_pkg::CH_DOT);
            add_digits(1, 3);
        end
        if ($urandom_range(0, 2) == 0) begin
            text.push_back($urandom_range(0, 1) ? pdt_pkg::CH_LO_E : pdt_pkg::CH_UP_E);
            case ($urandom_range(0, 2))
                0: text.push_back(pdt_pkg::CH_MINUS);
                1: text.push_back(pdt_pkg::CH_PLUS);
                default: ;
            endcase
            add_digits(1, 2);
        end
    endfunction

    // Defect: stray byte, number still wanting a digit, or a bad continuation
    function automatic void add_defect();
        case ($urandom_range(0, 7))
            0: text.push_back(pdt_pkg::CH_DOT);
            1: text.push_back(8'($urandom_range(8'h80, 8'hFF)));
            2: text.push_back(8'($urandom_range(1, 8)));
            3: text.push_back($urandom_range(0, 1) ? pdt_pkg::CH_MINUS : pdt_pkg::CH_PLUS);
            4: begin
                add_digits(1, 3);
                text.push_back(pdt_pkg::CH_DOT);
            end
            5: begin
                add_digits(1, 3);
                text.push_back(pdt_pkg::CH_LO_E);
            end
            6: begin
                add_digits(1, 3);
                text.push_back(pdt_pkg::CH_UP_E);
                text.push_back($urandom_range(0, 1) ? pdt_pkg::CH_MINUS : pdt_pkg::CH_PLUS);
            end
            default: begin
                add_number();
                case ($urandom_range(0, 3))
                    0: text.push_back(pick_letter());
                    1: text.push_back(pdt_pkg::CH_DOT);
                    2: text.push_back(pdt_pkg::CH_PLUS);
                    default: text.push_back(8'($urandom_range(8'h80, 8'hFF)));
                endcase
            end
        endcase
        // Tail after the defect, often ignored until the NUL
        repeat ($urandom_range(0, 3)) text.push_back(8'($urandom_range(1, 255)));
    endfunction

    // One random string, mostly well-formed, ending in NUL
    function automatic void build_random_string();
        int tokens;
        int defect_at;
        bit broken;
        tokens    = $urandom_range(1, 10);
        defect_at = $urandom_range(0, tokens - 1);
        broken    = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 19) == 0) begin
            // Pure noise, any byte value
            repeat ($urandom_range(1, 8)) text.push_back(8'($urandom_range(0, 255)));
            text.push_back(pdt_pkg::CH_NUL);
            return;
        end
        if ($urandom_range(0, 3) == 0) text.push_back(pick_space());
        for (int i = 0; i < tokens; i++) begin
            if (broken && i == defect_at) begin
                add_defect();
                break;
            end
            case ($urandom_range(0, 4))
                0, 1: begin
                    add_number();
                    if (i != tokens - 1 || $urandom_range(0, 1)) begin
                        if ($urandom_range(0, 1)) text.push_back(pdt_pkg::CH_COMMA);
                        else repeat ($urandom_range(1, 3)) text.push_back(pick_space());
                    end
                end
                2: text.push_back(pick_letter());
                3: text.push_back(pdt_pkg::CH_COMMA);
                default: repeat ($urandom_range(1, 3)) text.push_back(pick_space());
            endcase
        end
        text.push_back(pdt_pkg::CH_NUL);
    endfunction

    initial begin
        int random_base;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: every token kind, stray byte, malformed and cut numbers
        send_literal("M-1.5e+3,7E2\t.5");
        send_literal("1e");
        send_literal("+2x");
        send_literal("9");
        text.push_back(8'hFF);
        text.push_back(pdt_pkg::CH_NUL);
        send_buffer();
        wait_drained();

        // Random strings, with an occasional full drain
        random_base = bytes_sent;
        while (bytes_sent - random_base < RANDOM_BYTES) begin
            build_random_string();
            send_buffer();
            if ($urandom_range(0, 39) == 0) wait_drained();
        end

        wait_drained();
        repeat (30) @(posedge clk);
        $display("summary: %0d bytes in %0d strings, %0d tokens checked",
                 bytes_sent, strings_sent, token_count);
        $display("summary: corner strings, then random clean and broken strings");
        if (fail_count == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule

FILE: path_data_tokenizer.f
hdl/pdt_pkg.sv
hdl/path_data_tokenizer.sv
dv/path_token_checker.sv
dv/testbench.sv
